// ===== src/assert_macros.svh =====
// assertion macros for the rtl files, used by cslm_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSLM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define CSLM_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
	else $error("forbidden condition");
`else
`define CSLM_ASSERT(lbl, clk, rstn, prop)
`define CSLM_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== src/cslm_pkg.sv =====
// shared types and constants of the speed limited move block
// no dependencies
package cslm_pkg;

	localparam logic KIND_SET  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [15:0] STEP_RESET = 16'd210;
	localparam logic signed [31:0] Z_RESET = -32'sd19661;

	typedef struct packed {
		logic       load_goal;
		logic       delta;
		logic       sq_step;
		logic [1:0] sq_sel;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       mul;
		logic       div_step;
		logic       update;
		logic       snap;
		logic       publish;
	} cmd_t;

	typedef struct packed {
		logic snap_ok;
	} status_t;

endpackage

// ===== src/cslm_datapath.sv =====
// datapath: position, target, squared distance, root and three dividers
// depends on cslm_pkg
module cslm_datapath #(
	parameter int COORD_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [15:0]                  cfg_data,
	input  logic signed [COORD_BITS-1:0] goal_x,
	input  logic signed [COORD_BITS-1:0] goal_y,
	input  logic signed [COORD_BITS-1:0] goal_z,
	input  cslm_pkg::cmd_t               cmd,
	output cslm_pkg::status_t            status,
	output logic signed [COORD_BITS-1:0] pos_x,
	output logic signed [COORD_BITS-1:0] pos_y,
	output logic signed [COORD_BITS-1:0] pos_z,
	output logic                         at_target
);
	localparam int C    = COORD_BITS;
	localparam int MW   = C + 1;
	localparam int SW   = 2 * C + 2;
	localparam int NW   = 2 * C + 4;
	localparam int RW   = C + 2;
	localparam int REMW = C + 4;
	localparam int PW   = C + 17;
	// compare width, wide enough for the squared distance and step squared
	localparam int LW   = (SW > 32) ? SW : 32;

	logic [15:0] step_q;
	logic signed [C-1:0] cur_q [3];
	logic signed [C-1:0] tgt_q [3];
	logic signed [C:0]   dlt_q [3];
	logic [SW-1:0]   sum_q;
	logic [NW-1:0]   rad_q;
	logic [RW-1:0]   root_q;
	logic [REMW-1:0] rem_q;
	logic [PW-1:0]   dv_q [3];
	logic [RW-1:0]   dr_q [3];

	logic [MW-1:0]   mag [3];
	logic [MW-1:0]   sel_mag;
	logic [SW-1:0]   sq;
	logic [31:0]     lim;
	logic [REMW-1:0] rem_nx;
	logic [REMW-1:0] trial;
	logic signed [C-1:0] goal [3];

	assign goal[0] = goal_x;
	assign goal[1] = goal_y;
	assign goal[2] = goal_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = dlt_q[i][C] ? MW'(-dlt_q[i]) : MW'(dlt_q[i]);
		end
		case (cmd.sq_sel)
			2'd0: sel_mag = mag[0];
			2'd1: sel_mag = mag[1];
			default: sel_mag = mag[2];
		endcase
		sq = SW'(sel_mag) * SW'(sel_mag);
		lim = 32'(step_q) * 32'(step_q);
		status.snap_ok = (LW'(sum_q) <= LW'(lim));
		rem_nx = {rem_q[REMW-3:0], rad_q[NW-1:NW-2]};
		trial = {root_q, 2'b01};
	end

	// step length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cslm_pkg::STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_data;
		end
	end

	// position and target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q[0] <= '0;
			cur_q[1] <= '0;
			cur_q[2] <= cslm_pkg::Z_RESET[C-1:0];
			tgt_q[0] <= '0;
			tgt_q[1] <= '0;
			tgt_q[2] <= cslm_pkg::Z_RESET[C-1:0];
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (cmd.load_goal) begin
					tgt_q[i] <= goal[i];
				end
				if (cmd.snap) begin
					cur_q[i] <= tgt_q[i];
				end else if (cmd.update) begin
					cur_q[i] <= dlt_q[i][C]
						? C'({cur_q[i][C-1], cur_q[i]} - (C+1)'(dv_q[i][MW-1:0]))
						: C'({cur_q[i][C-1], cur_q[i]} + (C+1)'(dv_q[i][MW-1:0]));
				end
			end
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk) begin
		if (cmd.delta) begin
			for (int i = 0; i < 3; i++) begin
				dlt_q[i] <= {tgt_q[i][C-1], tgt_q[i]} - {cur_q[i][C-1], cur_q[i]};
			end
			sum_q <= '0;
		end
		if (cmd.sq_step) begin
			sum_q <= sum_q + sq;
		end
		if (cmd.sqrt_init) begin
			rad_q  <= NW'(sum_q);
			root_q <= '0;
			rem_q  <= '0;
		end
		// one root bit a cycle
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[NW-3:0], 2'b00};
			if (rem_nx >= trial) begin
				rem_q  <= rem_nx - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_nx;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (cmd.mul) begin
				dv_q[i] <= PW'(mag[i]) * PW'(step_q);
				dr_q[i] <= '0;
			end
			// restoring divide, quotient shifts into dv
			if (cmd.div_step) begin
				if ({dr_q[i], dv_q[i][PW-1]} >= {1'b0, root_q}) begin
					dr_q[i] <= RW'({dr_q[i], dv_q[i][PW-1]} - {1'b0, root_q});
					dv_q[i] <= {dv_q[i][PW-2:0], 1'b1};
				end else begin
					dr_q[i] <= RW'({dr_q[i], dv_q[i][PW-1]});
					dv_q[i] <= {dv_q[i][PW-2:0], 1'b0};
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			pos_x     <= cur_q[0];
			pos_y     <= cur_q[1];
			pos_z     <= cur_q[2];
			at_target <= (cur_q[0] == tgt_q[0]) && (cur_q[1] == tgt_q[1])
				&& (cur_q[2] == tgt_q[2]);
		end
	end

endmodule

// ===== src/cslm_ctrl.sv =====
// controller state machine sequencing one request at a time
// depends on cslm_pkg and assert_macros.svh
`include "assert_macros.svh"
module cslm_ctrl #(
	parameter int COORD_BITS = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	output logic              out_valid,
	input  logic              out_ready,
	input  cslm_pkg::status_t status,
	output cslm_pkg::cmd_t    cmd
);
	localparam int RW = COORD_BITS + 2;
	localparam int PW = COORD_BITS + 17;
	localparam int CW = $clog2(PW + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_DELTA, S_SQ, S_CMP, S_SQRT, S_MUL, S_DIV, S_OUT
	} state_t;

	state_t      state_q;
	logic [CW-1:0] cnt_q;
	logic        out_valid_q;
	logic        in_fire;
	logic        can_pub;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign can_pub   = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.load_goal = in_fire && (kind == cslm_pkg::KIND_SET);
		cmd.sq_sel    = cnt_q[1:0];
		case (state_q)
			S_DELTA: cmd.delta = 1'b1;
			S_SQ:    cmd.sq_step = 1'b1;
			S_CMP: begin
				cmd.sqrt_init = 1'b1;
				cmd.snap      = status.snap_ok;
			end
			S_SQRT:  cmd.sqrt_step = 1'b1;
			S_MUL:   cmd.mul = 1'b1;
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.update   = (cnt_q == CW'(PW));
			end
			S_OUT:   cmd.publish = can_pub;
			default: ;
		endcase
		// last divide cycle only updates, no extra step
		if (state_q == S_DIV && cnt_q == CW'(PW)) begin
			cmd.div_step = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in S_OUT the publish branch below decides the valid flag
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= (kind == cslm_pkg::KIND_TICK) ? S_DELTA : S_OUT;
					end
				end
				S_DELTA: begin
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(2)) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					cnt_q   <= '0;
					state_q <= status.snap_ok ? S_OUT : S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(RW - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(PW)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (can_pub) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CSLM_ASSERT(a_busy_after_accept, clk, arst_n, in_fire |=> !in_ready)
	`CSLM_NEVER(a_publish_overwrites, clk, arst_n, cmd.publish && out_valid_q && !out_ready)
	`CSLM_ASSERT(a_div_count_bound, clk, arst_n, (state_q == S_DIV) |-> (cnt_q <= CW'(PW)))

endmodule

// ===== src/cartesian_speed_limited_move.sv =====
// top level of the constant speed point to point move
// depends on cslm_pkg, cslm_ctrl and cslm_datapath
//
// keeps a 3d position and a target; a set-target request replaces the target,
// a tick request moves the position toward it by at most step_length along the
// straight line, snapping onto the target when it is within reach. every request
// gives one result with the new position and an at-target flag. one request is
// in work at a time: a set-target goes from accept to the output state; a tick
// runs delta, squaring, compare, the one-bit-a-cycle square root, multiply and
// the one-bit-a-cycle dividers (three, one per axis, running together); a tick
// that snaps goes from compare to the output state. a finished result waits in
// the output register while the next request is taken. the user writes step_length
// only while idle, through the always ready cfg channel; the block does not check.
module cartesian_speed_limited_move #(
	parameter int COORD_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [15:0]                  cfg_data,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic signed [COORD_BITS-1:0] goal_x,
	input  logic signed [COORD_BITS-1:0] goal_y,
	input  logic signed [COORD_BITS-1:0] goal_z,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] pos_x,
	output logic signed [COORD_BITS-1:0] pos_y,
	output logic signed [COORD_BITS-1:0] pos_z,
	output logic                         at_target
);
	cslm_pkg::cmd_t    cmd;
	cslm_pkg::status_t status;

	// register is always writable
	assign cfg_ready = 1'b1;

	cslm_ctrl #(
		.COORD_BITS(COORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cslm_datapath #(
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.goal_x    (goal_x),
		.goal_y    (goal_y),
		.goal_z    (goal_z),
		.cmd       (cmd),
		.status    (status),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.at_target (at_target)
	);

endmodule
